[sv/barometric_sensor_compensation_top_defines.svh]
// assertion macros for the barometric compensation block
// used by barometric_sensor_compensation_top only; needs clk and rst in scope
`ifndef BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`ifndef SYNTH
`define BSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsc check failed");
`define BSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsc check failed");
`else
`define BSC_ASSERT_SAME(label, ante, cons)
`define BSC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/bsc_pkg.sv]
// shared types, constants and multiply helpers for the barometric compensation block
// no dependencies
package bsc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } result_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  // sideband carried alongside the divider
  typedef struct packed {
    logic [31:0] centi;
    logic        pvalid;
    logic        qneg;
  } side_t;

  // partial products of a 64 x 64 multiply, low half only
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  typedef enum logic [2:0] {
    REG_T12  = 3'd0,
    REG_T3P1 = 3'd1,
    REG_P23  = 3'd2,
    REG_P45  = 3'd3,
    REG_P67  = 3'd4,
    REG_P89  = 3'd5
  } reg_idx_t;

  localparam int FrontStages = 13;
  localparam int DivSteps    = 64;
  localparam int BackStages  = 7;

  localparam logic [31:0]        TempRound  = 32'd128;
  localparam logic signed [32:0] TempOffset = 33'sd128000;
  localparam logic [20:0]        PressFull  = 21'd1048576;
  localparam logic [63:0]        PressScale = 64'd3125;
  localparam logic [63:0]        PressBias  = 64'h0000_8000_0000_0000;

  function automatic logic [63:0] sext16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic pp_t mul_pp(input logic [63:0] x, input logic [63:0] y);
    pp_t r;
    r.ll = x[31:0] * y[31:0];
    r.lh = x[31:0] * y[63:32];
    r.hl = x[63:32] * y[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t pp);
    logic [31:0] mid;
    mid = pp.lh + pp.hl;
    return pp.ll + {mid, 32'd0};
  endfunction

endpackage

[sv/bsc_front.sv]
// front pipeline: temperature, dividend and divisor of the pressure path
// depends on bsc_pkg
module bsc_front import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  sample_t     in_data,
  input  coef_t       coef,
  output logic        out_valid,
  output logic [63:0] nmag,
  output logic [30:0] dmag,
  output side_t       side
);

  logic [FrontStages-1:0] v;

  logic signed [17:0] s1_d1, s1_d2;
  logic [20:0] s1_p21, s2_p21, s3_p21, s4_p21, s5_p21, s6_p21, s7_p21, s8_p21, s9_p21;
  logic [31:0] s2_v1, s2_sq, s3_v1, s3_v2, s4_fine;
  logic [31:0] s5_centi, s6_centi, s7_centi, s8_centi, s9_centi, s10_centi, s11_centi;
  logic [31:0] s12_centi;
  logic signed [32:0] s5_a;
  logic [63:0] s6_aa;
  logic signed [48:0] s6_ap5, s6_ap2, s7_ap5, s7_ap2, s8_ap5, s8_ap2;
  pp_t s7_pp6, s7_pp3, s10_ppx, s11_ppn;
  logic [63:0] s8_b1, s8_c1, s9_b, s9_x, s10_num0, s11_ax, s12_num;
  logic [30:0] s12_den;

  logic signed [33:0] m1;
  logic signed [35:0] sq_full;
  logic signed [31:0] m3;
  logic [31:0]        f5;
  logic signed [65:0] aa_full;
  logic signed [48:0] ap5, ap2;
  logic [63:0]        b_sum, x_sum;

  assign m1      = s1_d1 * coef.t2;
  assign sq_full = s1_d2 * s1_d2;
  assign m3      = $signed(s2_sq) * coef.t3;
  assign f5      = (s4_fine << 2) + s4_fine + TempRound;
  assign aa_full = s5_a * s5_a;
  assign ap5     = s5_a * coef.p5;
  assign ap2     = s5_a * coef.p2;
  assign b_sum   = s8_b1 + ({{15{s8_ap5[48]}}, s8_ap5} << 17) + (sext16(coef.p4) << 35);
  assign x_sum   = 64'($signed(s8_c1) >>> 8) + ({{15{s8_ap2[48]}}, s8_ap2} << 12)
                 + PressBias;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[FrontStages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: differences against t1
      s1_d1  <= $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
      s1_d2  <= $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
      s1_p21 <= PressFull - {1'b0, in_data.raw_pressure};
      // stage 2
      s2_v1  <= 32'($signed(m1[31:0]) >>> 11);
      s2_sq  <= 32'($signed(sq_full[31:0]) >>> 12);
      s2_p21 <= s1_p21;
      // stage 3
      s3_v1  <= s2_v1;
      s3_v2  <= 32'(m3 >>> 14);
      s3_p21 <= s2_p21;
      // stage 4: fine temperature
      s4_fine <= s3_v1 + s3_v2;
      s4_p21  <= s3_p21;
      // stage 5
      s5_centi <= 32'($signed(f5) >>> 8);
      s5_a     <= $signed({s4_fine[31], s4_fine}) - TempOffset;
      s5_p21   <= s4_p21;
      // stage 6
      s6_aa    <= aa_full[63:0];
      s6_ap5   <= ap5;
      s6_ap2   <= ap2;
      s6_centi <= s5_centi;
      s6_p21   <= s5_p21;
      // stage 7
      s7_pp6   <= mul_pp(s6_aa, sext16(coef.p6));
      s7_pp3   <= mul_pp(s6_aa, sext16(coef.p3));
      s7_ap5   <= s6_ap5;
      s7_ap2   <= s6_ap2;
      s7_centi <= s6_centi;
      s7_p21   <= s6_p21;
      // stage 8
      s8_b1    <= mul_sum(s7_pp6);
      s8_c1    <= mul_sum(s7_pp3);
      s8_ap5   <= s7_ap5;
      s8_ap2   <= s7_ap2;
      s8_centi <= s7_centi;
      s8_p21   <= s7_p21;
      // stage 9
      s9_b     <= b_sum;
      s9_x     <= x_sum;
      s9_centi <= s8_centi;
      s9_p21   <= s8_p21;
      // stage 10
      s10_ppx   <= mul_pp(s9_x, {48'd0, coef.p1});
      s10_num0  <= ({43'd0, s9_p21} << 31) - s9_b;
      s10_centi <= s9_centi;
      // stage 11
      s11_ax    <= mul_sum(s10_ppx);
      s11_ppn   <= mul_pp(s10_num0, PressScale);
      s11_centi <= s10_centi;
      // stage 12: divisor is the top 31 bits after the shift
      s12_den   <= s11_ax[63:33];
      s12_num   <= mul_sum(s11_ppn);
      s12_centi <= s11_centi;
      // stage 13: magnitudes and quotient sign
      nmag        <= s12_num[63] ? (64'd0 - s12_num) : s12_num;
      dmag        <= s12_den[30] ? (31'd0 - s12_den) : s12_den;
      side.centi  <= s12_centi;
      side.pvalid <= (s12_den != 31'd0);
      side.qneg   <= s12_num[63] ^ s12_den[30];
    end
  end

  assign out_valid = v[FrontStages-1];

endmodule

[sv/bsc_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on bsc_pkg
module bsc_div import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] nmag,
  input  logic [30:0] dmag,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [63:0] quot,
  output side_t       out_side
);

  logic [DivSteps-1:0] v;
  logic [30:0] rem  [1:DivSteps];
  logic [63:0] nq   [1:DivSteps];
  logic [30:0] dm   [1:DivSteps];
  side_t       sd   [1:DivSteps];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[DivSteps-2:0], in_valid};
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [30:0] rem_in;
    logic [63:0] nq_in;
    logic [30:0] dm_in;
    side_t       sd_in;
    logic [31:0] trial;
    logic        ge;

    if (k == 1) begin : g_first
      assign rem_in = '0;
      assign nq_in  = nmag;
      assign dm_in  = dmag;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign nq_in  = nq[k-1];
      assign dm_in  = dm[k-1];
      assign sd_in  = sd[k-1];
    end

    assign trial = {rem_in, nq_in[63]};
    assign ge    = (trial >= {1'b0, dm_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? 31'(trial - {1'b0, dm_in}) : trial[30:0];
        nq[k]  <= {nq_in[62:0], ge};
        dm[k]  <= dm_in;
        sd[k]  <= sd_in;
      end
    end
  end

  assign out_valid = v[DivSteps-1];
  assign quot      = nq[DivSteps];
  assign out_side  = sd[DivSteps];

endmodule

[sv/bsc_back.sv]
// back pipeline: sign of the quotient, second-order pressure terms, saturation
// depends on bsc_pkg
module bsc_back import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] quot,
  input  side_t       in_side,
  input  coef_t       coef,
  output logic        out_valid,
  output result_t     out_data
);

  logic [BackStages-1:0] v;
  logic [63:0] b1_p, b1_q, b2_p, b2_q, b3_p, b3_q, b3_t9q, b3_t8p, b4_p, b4_bt;
  logic [63:0] b5_p, b5_at, b5_bt, b6_s;
  pp_t b2_pp9, b2_pp8, b4_pp;
  side_t b1_sd, b2_sd, b3_sd, b4_sd, b5_sd, b6_sd;
  logic [63:0] p_signed, pf;
  logic [31:0] press;

  assign p_signed = in_side.qneg ? (64'd0 - quot) : quot;
  assign pf       = 64'($signed(b6_s) >>> 8) + (sext16(coef.p7) << 4);

  always_comb begin
    if (!b6_sd.pvalid || pf[63]) begin
      press = '0;
    end else if (|pf[62:32]) begin
      press = '1;
    end else begin
      press = pf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[BackStages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_p   <= p_signed;
      b1_q   <= 64'($signed(p_signed) >>> 13);
      b1_sd  <= in_side;
      b2_pp9 <= mul_pp(sext16(coef.p9), b1_q);
      b2_pp8 <= mul_pp(sext16(coef.p8), b1_p);
      b2_p   <= b1_p;
      b2_q   <= b1_q;
      b2_sd  <= b1_sd;
      b3_t9q <= mul_sum(b2_pp9);
      b3_t8p <= mul_sum(b2_pp8);
      b3_p   <= b2_p;
      b3_q   <= b2_q;
      b3_sd  <= b2_sd;
      b4_pp  <= mul_pp(b3_t9q, b3_q);
      b4_bt  <= 64'($signed(b3_t8p) >>> 19);
      b4_p   <= b3_p;
      b4_sd  <= b3_sd;
      b5_at  <= 64'($signed(mul_sum(b4_pp)) >>> 25);
      b5_bt  <= b4_bt;
      b5_p   <= b4_p;
      b5_sd  <= b4_sd;
      b6_s   <= b5_p + b5_at + b5_bt;
      b6_sd  <= b5_sd;
      // output register
      out_data.temperature_centi <= $signed(b6_sd.centi);
      out_data.pressure_q24_8    <= press;
      out_data.pressure_valid    <= b6_sd.pvalid;
    end
  end

  assign out_valid = v[BackStages-1];

endmodule

[sv/barometric_sensor_compensation_top.sv]
// top level of the barometric compensation block: calibration registers and pipeline
// depends on bsc_pkg, bsc_front, bsc_div, bsc_back and the assertion header
//
// usage
// - sample channel: sample_valid / sample_stall / sample carries one raw temperature
//   and one raw pressure reading; a request is taken when valid is high and stall low
// - result channel: result_valid / result_stall / result gives compensated temperature
//   in centidegrees, pressure in q24.8 pascals (saturated) and a pressure valid flag
// - calibration words sit in six 32-bit registers on the apb port, two words each,
//   first word in the low half; write them only while no request is in flight
// - the pipe has 13 front stages, 64 divider stages (one quotient bit each)
//   and 7 back stages, the last of which is the output register
// - throughput is one request per cycle while no held result freezes the pipe; the 64-stage divider sets the depth
// - a zero divisor gives pressure 0 with the valid flag cleared
// - reset clears the calibration registers and all stage valid bits
// - when the receiver stalls a held result, the whole pipe freezes and sample_stall
//   rises in the same cycle; nothing is dropped or repeated
`include "barometric_sensor_compensation_top_defines.svh"
module barometric_sensor_compensation_top import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // calibration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] reg_t12, reg_t3p1, reg_p23, reg_p45, reg_p67, reg_p89;
  coef_t       coef;
  logic        adv;
  reg_idx_t    idx;

  // front to divider
  logic        f_valid;
  logic [63:0] f_nmag;
  logic [30:0] f_dmag;
  side_t       f_side;

  // divider to back
  logic        d_valid;
  logic [63:0] d_quot;
  side_t       d_side;

  // ---- calibration registers ----
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_t12  <= '0;
      reg_t3p1 <= '0;
      reg_p23  <= '0;
      reg_p45  <= '0;
      reg_p67  <= '0;
      reg_p89  <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_T12:  reg_t12  <= pwdata;
        REG_T3P1: reg_t3p1 <= pwdata;
        REG_P23:  reg_p23  <= pwdata;
        REG_P45:  reg_p45  <= pwdata;
        REG_P67:  reg_p67  <= pwdata;
        REG_P89:  reg_p89  <= pwdata;
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T12:  prdata = reg_t12;
      REG_T3P1: prdata = reg_t3p1;
      REG_P23:  prdata = reg_p23;
      REG_P45:  prdata = reg_p45;
      REG_P67:  prdata = reg_p67;
      REG_P89:  prdata = reg_p89;
      default:  prdata = '0;
    endcase
  end

  // unpack the calibration words, first word in the low half
  assign coef.t1 = reg_t12[15:0];
  assign coef.t2 = $signed(reg_t12[31:16]);
  assign coef.t3 = $signed(reg_t3p1[15:0]);
  assign coef.p1 = reg_t3p1[31:16];
  assign coef.p2 = $signed(reg_p23[15:0]);
  assign coef.p3 = $signed(reg_p23[31:16]);
  assign coef.p4 = $signed(reg_p45[15:0]);
  assign coef.p5 = $signed(reg_p45[31:16]);
  assign coef.p6 = $signed(reg_p67[15:0]);
  assign coef.p7 = $signed(reg_p67[31:16]);
  assign coef.p8 = $signed(reg_p89[15:0]);
  assign coef.p9 = $signed(reg_p89[31:16]);

  // ---- pipeline control ----
  // the pipe moves unless a finished result is being held by the receiver
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample_valid),
    .in_data   (sample),
    .coef      (coef),
    .out_valid (f_valid),
    .nmag      (f_nmag),
    .dmag      (f_dmag),
    .side      (f_side)
  );

  bsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .nmag      (f_nmag),
    .dmag      (f_dmag),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .out_side  (d_side)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .quot      (d_quot),
    .in_side   (d_side),
    .coef      (coef),
    .out_valid (result_valid),
    .out_data  (result)
  );

  // ---- checks ----
  // input side only waits on a held result
  `BSC_ASSERT_SAME(a_stall_cause, sample_stall, result_valid && result_stall)
  // a zero divisor always reads as pressure zero
  `BSC_ASSERT_SAME(a_zero_div, result_valid && !result.pressure_valid, result.pressure_q24_8 == 32'd0)
  // a frozen pipe keeps the divider output in place
  `BSC_ASSERT_NEXT(a_div_hold, !adv, $stable(d_valid) && $stable(d_quot))

endmodule

[bench/barometric_sensor_compensation_top_tb.sv]
// testbench for barometric_sensor_compensation_top: directed and random sample pairs
// checked against an in-bench integer compensation predictor; depends on bsc_pkg
module barometric_sensor_compensation_top_tb;
  import bsc_pkg::*;

  localparam int PipeDepth  = 84;
  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_stall;
  sample_t     sample;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // calibration registers as the predictor sees them
  logic [31:0] cal [6];
  // compensated readings still owed by the block, oldest first
  result_t     expected_readings [$];
  int          mismatches;
  int          cycles;
  // random idling on both channels, switched off for one stretch
  bit          idling_on;

  barometric_sensor_compensation_top uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // standard integer compensation, wrapping at 32 bits for temperature, 64 for pressure
  function automatic result_t compensate(sample_t s);
    logic [31:0] t1, t2, t3, d1, d2, v1, v2, fine, m;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, x, p, q, num;
    logic signed [63:0] sn, sd, sp;
    result_t r;
    t1 = {16'd0, cal[REG_T12][15:0]};
    t2 = {{16{cal[REG_T12][31]}}, cal[REG_T12][31:16]};
    t3 = {{16{cal[REG_T3P1][15]}}, cal[REG_T3P1][15:0]};
    p1 = {48'd0, cal[REG_T3P1][31:16]};
    p2 = {{48{cal[REG_P23][15]}}, cal[REG_P23][15:0]};
    p3 = {{48{cal[REG_P23][31]}}, cal[REG_P23][31:16]};
    p4 = {{48{cal[REG_P45][15]}}, cal[REG_P45][15:0]};
    p5 = {{48{cal[REG_P45][31]}}, cal[REG_P45][31:16]};
    p6 = {{48{cal[REG_P67][15]}}, cal[REG_P67][15:0]};
    p7 = {{48{cal[REG_P67][31]}}, cal[REG_P67][31:16]};
    p8 = {{48{cal[REG_P89][15]}}, cal[REG_P89][15:0]};
    p9 = {{48{cal[REG_P89][31]}}, cal[REG_P89][31:16]};
    // fine temperature
    d1 = {15'd0, s.raw_temperature[19:3]} - (t1 << 1);
    m = d1 * t2;
    v1 = $signed(m) >>> 11;
    d2 = {16'd0, s.raw_temperature[19:4]} - t1;
    m = d2 * d2;
    m = $signed(m) >>> 12;
    m = m * t3;
    v2 = $signed(m) >>> 14;
    fine = v1 + v2;
    m = fine * 32'd5 + 32'd128;
    r.temperature_centi = $signed(m) >>> 8;
    // pressure divisor
    a = {{32{fine[31]}}, fine} - 64'd128000;
    b = a * a * p6 + ((a * p5) << 17) + (p4 << 35);
    x = a * a * p3;
    x = $signed(x) >>> 8;
    x = x + ((a * p2) << 12);
    x = (64'h0000_8000_0000_0000 + x) * p1;
    x = $signed(x) >>> 33;
    if (x == 64'd0) begin
      r.pressure_q24_8 = 32'd0;
      r.pressure_valid = 1'b0;
    end else begin
      p = 64'd1048576 - {44'd0, s.raw_pressure};
      num = ((p << 31) - b) * 64'd3125;
      // minus one divisor handled apart so the most negative dividend wraps
      if (x == 64'hFFFF_FFFF_FFFF_FFFF) begin
        p = 64'd0 - num;
      end else begin
        sn = num;
        sd = x;
        sp = sn / sd;
        p = sp;
      end
      q = $signed(p) >>> 13;
      a = p9 * q * q;
      a = $signed(a) >>> 25;
      b = p8 * p;
      b = $signed(b) >>> 19;
      x = p + a + b;
      x = $signed(x) >>> 8;
      p = x + (p7 << 4);
      sp = p;
      if (sp < 0) r.pressure_q24_8 = 32'd0;
      else if (sp > 64'sh0000_0000_FFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // apb write: setup cycle then access cycle
  task automatic write_cal(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cal[idx] = value;
  endtask

  task automatic load_cal(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                          logic [31:0] r3, logic [31:0] r4, logic [31:0] r5);
    write_cal(REG_T12, r0);
    write_cal(REG_T3P1, r1);
    write_cal(REG_P23, r2);
    write_cal(REG_P45, r3);
    write_cal(REG_P67, r4);
    write_cal(REG_P89, r5);
  endtask

  // typical factory calibration words
  task automatic load_typical_cal();
    load_cal({16'd26435, 16'd27504}, {16'd36477, 16'hFC18}, {16'd3024, 16'hD643},
             {16'd140, 16'd2855}, {16'd15500, 16'hFFF9}, {16'd6000, 16'hC6F8});
  endtask

  // one request: optional gap, then hold valid until taken
  task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p);
    sample_t s;
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(99) < 14) begin
      sample_valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    s.raw_temperature = raw_t;
    s.raw_pressure = raw_p;
    sample = s;
    sample_valid = 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_readings.push_back(compensate(s));
  endtask

  task automatic send_random_sample();
    send_sample(20'($urandom), 20'($urandom));
  endtask

  // readings near the usual operating point of the converter
  task automatic send_realistic_sample();
    send_sample(20'($urandom_range(380000, 620000)), 20'($urandom_range(250000, 480000)));
  endtask

  // sender pauses until the pipe has emptied, then a little longer
  task automatic drain();
    @(negedge clk);
    sample_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (PipeDepth + 6) @(posedge clk);
  endtask

  // reset calibration: all zero, so the divisor is zero for every request
  task automatic test_reset_cal();
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    drain();
  endtask

  // field extremes with typical calibration
  task automatic test_field_extremes();
    load_typical_cal();
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h80000, 20'h7FFFF);
    drain();
  endtask

  // extreme calibration words: all ones, all negative, all most positive
  task automatic test_cal_extremes();
    load_cal('1, '1, '1, '1, '1, '1);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    load_cal(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
             32'h8000_8000, 32'h8000_8000);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();
    load_cal(32'h7FFF_FFFF, 32'hFFFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
             32'h7FFF_7FFF, 32'h7FFF_7FFF);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  // zero divisor with live temperature: pressure coefficient 1 cleared
  task automatic test_zero_divisor();
    load_cal({16'd26435, 16'd27504}, {16'd0, 16'hFC18}, {16'd3024, 16'hD643},
             {16'd140, 16'd2855}, {16'd15500, 16'hFFF9}, {16'd6000, 16'hC6F8});
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'd0);
    drain();
  endtask

  // long run at realistic calibration, first stretch with no idling at all
  task automatic test_realistic_stream();
    load_typical_cal();
    idling_on = 1'b0;
    repeat (300) send_realistic_sample();
    idling_on = 1'b1;
    repeat (500) begin
      if ($urandom_range(99) < 80) send_realistic_sample();
      else send_random_sample();
    end
    drain();
  endtask

  // random calibration sets, perturbed around typical or fully random
  task automatic test_random_cal();
    repeat (10) begin
      if ($urandom_range(1)) begin
        load_cal({16'($urandom_range(24000, 30000)), 16'($urandom_range(26000, 29000))},
                 {16'($urandom_range(34000, 38000)), 16'hFC18 + 16'($urandom_range(200))},
                 {16'($urandom_range(2000, 4000)), 16'hD643 + 16'($urandom_range(400))},
                 {16'($urandom_range(50, 300)), 16'($urandom_range(1000, 9000))},
                 {16'($urandom_range(10000, 20000)), 16'hFFF9 - 16'($urandom_range(10))},
                 {16'($urandom_range(3000, 9000)), 16'hC6F8 + 16'($urandom_range(2000))});
      end else begin
        load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      repeat (90) begin
        if ($urandom_range(1)) send_realistic_sample();
        else send_random_sample();
      end
      drain();
    end
  endtask

  // result side stalls at random
  always @(negedge clk) begin
    if (rst) result_stall = 1'b0;
    else result_stall = idling_on && ($urandom_range(99) < 14);
  end

  // compare each taken result with the oldest owed reading
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = expected_readings.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp exp %0d got %0d, press exp %h got %h, valid exp %b got %b",
                     want.temperature_centi, result.temperature_centi,
                     want.pressure_q24_8, result.pressure_q24_8,
                     want.pressure_valid, result.pressure_valid);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycles = 0;
    idling_on = 1'b1;
    foreach (cal[i]) cal[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_cal();
    test_field_extremes();
    test_cal_extremes();
    test_zero_divisor();
    test_realistic_stream();
    test_random_cal();
    drain();

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_front.sv
sv/bsc_div.sv
sv/bsc_back.sv
sv/barometric_sensor_compensation_top.sv
bench/barometric_sensor_compensation_top_tb.sv
